[hw/rtl/dsq_pkg.sv]
// dsq_pkg: shared types and constants for the distance sample qualifier.
// Used by every module under hw/rtl; depends on nothing.
package dsq_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int SCALE_W    = 12;
  localparam int LIMIT_W    = 8;
  localparam int GAP_W      = 15;
  localparam int WIN_W      = 11;
  localparam int SUM_W      = 27;
  localparam int PROD_W     = SAMPLE_W + SCALE_W + 1;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int QDEPTH     = 2;

  localparam logic [WIN_W-1:0] WINDOW_MAX = 11'd1024;
  localparam logic [LIMIT_W-1:0] RUN_MAX  = 8'hFF;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SCALE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_NORMAL = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INV_LIMIT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAP        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW     = 3'd4;

  // item and result codes
  localparam logic KIND_SAMPLE  = 1'b0;
  localparam logic KIND_TICK    = 1'b1;
  localparam logic REPORT_ERROR = 1'b0;
  localparam logic REPORT_AVG   = 1'b1;

  typedef struct packed {
    logic [SCALE_W-1:0]          scale;
    logic signed [SAMPLE_W-1:0]  min_normal;
    logic [LIMIT_W-1:0]          invalid_limit;
    logic [GAP_W-1:0]            max_jump;
    logic [WIN_W-1:0]            window_length;
  } cfg_t;

  // work handed from front to back: an error value or a sum to divide
  typedef struct packed {
    logic                     report;
    logic signed [SUM_W-1:0]  num;
    logic [WIN_W-1:0]         den;
  } job_t;

endpackage

[hw/rtl/dsq_fifo.sv]
// dsq_fifo: two-entry job queue between front and back.
// Depends on dsq_pkg (job_t, QDEPTH).
module dsq_fifo
  import dsq_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t wr_job,
  output logic full,
  input  logic pop,
  output job_t rd_job,
  output logic empty
);

  localparam int PTR_W = $clog2(QDEPTH);
  localparam int CNT_W = $clog2(QDEPTH + 1);

  job_t              mem_r [QDEPTH];
  logic [PTR_W-1:0]  wr_ptr_r;
  logic [PTR_W-1:0]  rd_ptr_r;
  logic [CNT_W-1:0]  cnt_r;

  assign full   = (cnt_r == CNT_W'(QDEPTH));
  assign empty  = (cnt_r == '0);
  assign rd_job = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) !(push && full))
    else $error("job pushed into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) !(pop && empty))
    else $error("job popped from empty queue");
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
                                cnt_r <= CNT_W'(QDEPTH))
    else $error("queue count beyond depth");

endmodule

[hw/rtl/dsq_front.sv]
// dsq_front: accepts items, scales and qualifies samples, keeps run/window state
// and posts error or average jobs. Depends on dsq_pkg.
module dsq_front
  import dsq_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  cfg_t                       cfg,
  input  logic                       in_push,
  output logic                       in_full,
  input  logic                       in_kind,
  input  logic signed [SAMPLE_W-1:0] in_sample,
  output job_t                       job,
  output logic                       job_push,
  input  logic                       job_full
);

  typedef enum logic [1:0] {F_IDLE, F_MUL, F_EVAL} fstate_t;

  localparam logic signed [PROD_W-9:0] Q_MAX = (PROD_W-8)'(32767);
  localparam logic signed [PROD_W-9:0] Q_MIN = -(PROD_W-8)'(32768);
  localparam logic signed [SUM_W:0]    S_MAX = (SUM_W+1)'(67108863);
  localparam logic signed [SUM_W:0]    S_MIN = -(SUM_W+1)'(67108864);

  fstate_t                     state_r;
  logic                        kind_r;
  logic signed [SAMPLE_W-1:0]  sample_r;
  logic signed [PROD_W-1:0]    prod_r;
  logic [LIMIT_W-1:0]          run_r, run_nxt;
  logic signed [SAMPLE_W-1:0]  last_r, last_nxt;
  logic                        last_vld_r, last_vld_nxt;
  logic signed [SUM_W-1:0]     sum_r, sum_nxt;
  logic [WIN_W-1:0]            tick_r, tick_nxt;

  logic signed [PROD_W-1:0]    prod_sh;
  logic signed [PROD_W-9:0]    q;
  logic signed [SAMPLE_W-1:0]  v;
  logic signed [SAMPLE_W:0]    diff;
  logic [SAMPLE_W:0]           jump_abs;
  logic [LIMIT_W-1:0]          run_inc;
  logic [WIN_W-1:0]            tick_inc;
  logic [WIN_W-1:0]            win;
  logic signed [SAMPLE_W-1:0]  addend;
  logic                        do_add;
  logic signed [SUM_W:0]       sum_wide;
  logic signed [SUM_W-1:0]     sum_add;
  logic signed [SAMPLE_W-1:0]  v_whole;
  logic                        need_job;
  job_t                        job_c;

  assign in_full = (state_r != F_IDLE);

  always_comb begin
    // floor shift of the product with the Q4.8 scale, then clamp to Q11.4
    prod_sh = prod_r >>> 8;
    q = prod_sh[PROD_W-9:0];
    if (q > Q_MAX)      v = 16'sh7FFF;
    else if (q < Q_MIN) v = -16'sh8000;
    else                v = q[SAMPLE_W-1:0];

    diff = {v[SAMPLE_W-1], v} - {last_r[SAMPLE_W-1], last_r};
    jump_abs = diff[SAMPLE_W] ? (SAMPLE_W+1)'(-diff) : diff;

    run_inc  = (run_r == RUN_MAX) ? run_r : run_r + 1'b1;
    tick_inc = tick_r + 1'b1;

    if (cfg.window_length == '0)             win = WIN_W'(1);
    else if (cfg.window_length > WINDOW_MAX) win = WINDOW_MAX;
    else                                     win = cfg.window_length;

    // truncate toward zero to whole units
    if (!v[SAMPLE_W-1] || v[3:0] == 4'd0) v_whole = {v[SAMPLE_W-1:4], 4'd0};
    else                                  v_whole = {v[SAMPLE_W-1:4] + 1'b1, 4'd0};

    run_nxt      = run_r;
    last_nxt     = last_r;
    last_vld_nxt = last_vld_r;
    tick_nxt     = tick_inc;
    do_add       = 1'b0;
    addend       = v;
    need_job     = 1'b0;
    job_c.report = REPORT_AVG;
    job_c.num    = '0;
    job_c.den    = win;

    if (kind_r == KIND_SAMPLE) begin
      if (v < cfg.min_normal) begin
        run_nxt = run_inc;
      end else begin
        run_nxt = '0;
        do_add  = 1'b1;
        if (!last_vld_r || jump_abs < {2'b00, cfg.max_jump}) begin
          last_nxt     = v_whole;
          last_vld_nxt = 1'b1;
        end else begin
          addend = last_r;
        end
      end
    end

    sum_wide = {sum_r[SUM_W-1], sum_r} + (SUM_W+1)'(addend);
    if (!do_add)              sum_add = sum_r;
    else if (sum_wide > S_MAX) sum_add = S_MAX[SUM_W-1:0];
    else if (sum_wide < S_MIN) sum_add = S_MIN[SUM_W-1:0];
    else                       sum_add = sum_wide[SUM_W-1:0];
    sum_nxt = sum_add;

    if (kind_r == KIND_SAMPLE && v < cfg.min_normal && run_inc > cfg.invalid_limit) begin
      need_job     = 1'b1;
      job_c.report = REPORT_ERROR;
      job_c.num    = SUM_W'(v);
      tick_nxt     = '0;
      sum_nxt      = '0;
    end else if (tick_inc >= win) begin
      need_job     = 1'b1;
      job_c.num    = sum_add;
      tick_nxt     = '0;
      sum_nxt      = '0;
    end
  end

  assign job      = job_c;
  assign job_push = (state_r == F_EVAL) && !job_full && need_job;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= F_IDLE;
      run_r      <= '0;
      last_r     <= '0;
      last_vld_r <= 1'b0;
      sum_r      <= '0;
      tick_r     <= '0;
    end else begin
      unique case (state_r)
        F_IDLE: begin
          if (in_push) begin
            kind_r   <= in_kind;
            sample_r <= in_sample;
            state_r  <= F_MUL;
          end
        end
        F_MUL: begin
          prod_r  <= PROD_W'(sample_r) * $signed({1'b0, cfg.scale});
          state_r <= F_EVAL;
        end
        F_EVAL: begin
          // hold until the queue can take a job, whether one is needed or not
          if (!job_full) begin
            run_r      <= run_nxt;
            last_r     <= last_nxt;
            last_vld_r <= last_vld_nxt;
            sum_r      <= sum_nxt;
            tick_r     <= tick_nxt;
            state_r    <= F_IDLE;
          end
        end
        default: state_r <= F_IDLE;
      endcase
    end
  end

endmodule

[hw/rtl/dsq_back.sv]
// dsq_back: takes jobs from the queue, divides window sums bit-serially and
// holds the finished result beat in the output register. Depends on dsq_pkg.
module dsq_back
  import dsq_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  job_t                       job,
  input  logic                       job_empty,
  output logic                       job_pop,
  output logic                       out_empty,
  input  logic                       out_pop,
  output logic                       out_report,
  output logic signed [SAMPLE_W-1:0] out_value
);

  typedef enum logic [1:0] {B_IDLE, B_DIV, B_DONE} bstate_t;

  localparam int CNT_W = $clog2(SUM_W);
  localparam int REM_W = WIN_W + 1;

  bstate_t                    state_r;
  logic                       rep_r;
  logic                       neg_r;
  logic [SUM_W-1:0]           quo_r;
  logic [REM_W-1:0]           rem_r;
  logic [WIN_W-1:0]           den_r;
  logic [CNT_W-1:0]           cnt_r;
  logic                       out_vld_r;
  logic                       out_rep_r;
  logic signed [SAMPLE_W-1:0] out_val_r;

  logic [REM_W-1:0]           rem_sh;
  logic                       fits;
  logic signed [SAMPLE_W-1:0] res;
  logic                       out_free;

  assign out_empty  = !out_vld_r;
  assign out_report = out_rep_r;
  assign out_value  = out_val_r;
  assign out_free   = !out_vld_r || out_pop;
  assign job_pop    = (state_r == B_IDLE) && !job_empty;

  always_comb begin
    rem_sh = {rem_r[REM_W-2:0], quo_r[SUM_W-1]};
    fits   = (rem_sh >= {1'b0, den_r});

    if (rep_r == REPORT_ERROR) begin
      res = quo_r[SAMPLE_W-1:0];
    end else if (!neg_r) begin
      res = (quo_r > SUM_W'(32767)) ? 16'sh7FFF : quo_r[SAMPLE_W-1:0];
    end else begin
      res = (quo_r > SUM_W'(32768)) ? -16'sh8000 : -quo_r[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= B_IDLE;
      out_vld_r <= 1'b0;
    end else begin
      // a new beat replaces the one being popped in the same cycle
      if (state_r == B_DONE && out_free) begin
        out_vld_r <= 1'b1;
      end else if (out_pop && out_vld_r) begin
        out_vld_r <= 1'b0;
      end
      unique case (state_r)
        B_IDLE: begin
          if (!job_empty) begin
            rep_r <= job.report;
            neg_r <= job.num[SUM_W-1];
            den_r <= job.den;
            rem_r <= '0;
            cnt_r <= '0;
            if (job.report == REPORT_AVG) begin
              quo_r   <= job.num[SUM_W-1] ? SUM_W'(-job.num) : job.num;
              state_r <= B_DIV;
            end else begin
              quo_r   <= job.num;
              state_r <= B_DONE;
            end
          end
        end
        B_DIV: begin
          // restoring divide, one quotient bit per cycle
          rem_r <= fits ? rem_sh - {1'b0, den_r} : rem_sh;
          quo_r <= {quo_r[SUM_W-2:0], fits};
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CNT_W'(SUM_W - 1)) begin
            state_r <= B_DONE;
          end
        end
        B_DONE: begin
          if (out_free) begin
            out_rep_r <= rep_r;
            out_val_r <= res;
            state_r   <= B_IDLE;
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

endmodule

[hw/rtl/distance_sample_qualifier.sv]
// distance_sample_qualifier: top level with configuration registers, front,
// job queue and back. Depends on dsq_pkg, dsq_front, dsq_fifo, dsq_back.
//  - Input channel is queue-like: a beat (in_kind, in_sample) is taken at a
//    clock edge with in_push high and in_full low. in_kind selects a distance
//    sample or an empty tick; every beat advances the window tick counter.
//  - Result channel is queue-like: out_report/out_value hold the oldest result
//    while out_empty is low; it is taken with out_pop high. A result is either
//    a small distance error (the scaled sample) or a window average.
//  - Configuration: cfg_valid/cfg_ready write channel, cfg_index selects the
//    register, cfg_data carries the value (truncated to the register width).
//    cfg_ready is always high; write only while the block is idle.
//  - Flow: the front handles one beat at a time (accept, multiply, qualify)
//    and takes no new beat until it has qualified the last, which waits while
//    the job queue is full. Averages go through a bit-serial divider over all
//    27 sum bits in the back; error results skip it. The back takes no new job
//    until its result is registered. A two-entry job queue buffers the jobs.
//  - Receiver stall: the result stays in the output register; the back holds
//    its next result, the queue fills, and then in_full stays high.
//  - Reset (rst_n low, synchronous): registers to their defaults, all window
//    and run state cleared, queue and output empty.
module distance_sample_qualifier
  import dsq_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_push,
  output logic                         in_full,
  input  logic                         in_kind,
  input  logic signed [SAMPLE_W-1:0]   in_sample,
  output logic                         out_empty,
  input  logic                         out_pop,
  output logic                         out_report,
  output logic signed [SAMPLE_W-1:0]   out_value,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data
);

  cfg_t cfg_r;
  job_t fe_job;
  job_t be_job;
  logic fe_push;
  logic q_full;
  logic q_empty;
  logic be_pop;

  assign cfg_ready = 1'b1;

  // Register file; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.scale          <= 12'd256;
      cfg_r.min_normal     <= '0;
      cfg_r.invalid_limit  <= 8'd3;
      cfg_r.max_jump       <= 15'd160;
      cfg_r.window_length  <= 11'd10;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SCALE:      cfg_r.scale          <= cfg_data[SCALE_W-1:0];
        REG_MIN_NORMAL: cfg_r.min_normal     <= cfg_data;
        REG_INV_LIMIT:  cfg_r.invalid_limit  <= cfg_data[LIMIT_W-1:0];
        REG_GAP:        cfg_r.max_jump       <= cfg_data[GAP_W-1:0];
        REG_WINDOW:     cfg_r.window_length  <= cfg_data[WIN_W-1:0];
        default:        cfg_r                <= cfg_r;
      endcase
    end
  end

  // Front: accept, scale, qualify, keep window state.
  dsq_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_kind   (in_kind),
    .in_sample (in_sample),
    .job       (fe_job),
    .job_push  (fe_push),
    .job_full  (q_full)
  );

  // Decouples the front from the divider and output stall.
  dsq_fifo u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (fe_push),
    .wr_job (fe_job),
    .full   (q_full),
    .pop    (be_pop),
    .rd_job (be_job),
    .empty  (q_empty)
  );

  // Back: divide window sums, register result beats.
  dsq_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .job        (be_job),
    .job_empty  (q_empty),
    .job_pop    (be_pop),
    .out_empty  (out_empty),
    .out_pop    (out_pop),
    .out_report (out_report),
    .out_value  (out_value)
  );

endmodule

[test/distance_sample_qualifier_test.sv]
// Self-checking testbench for distance_sample_qualifier: queue-style stimulus with random
// idling, an in-bench model of the qualifier, and in-order result checking.
// Depends on dsq_pkg and the distance_sample_qualifier RTL only.
`timescale 1ns / 1ps

module distance_sample_qualifier_test;
  import dsq_pkg::*;

  // The block can still be busy on a beat that yields no result after the last
  // result has come out, so wait this long.
  localparam int SETTLE_CYCLES = 64;
  localparam int SHOW_LIMIT    = 10;

  // register indexes the block does not decode; writes to them must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_C = 3'd7;

  typedef struct packed {
    logic                        kind;
    logic signed [SAMPLE_W-1:0]  sample;
  } dist_beat_t;

  typedef struct packed {
    logic                        report;
    logic signed [SAMPLE_W-1:0]  value;
  } dist_report_t;

  // DUT inputs, known from time zero
  logic                        clk       = 1'b0;
  logic                        rst_n     = 1'b0;
  logic                        in_push   = 1'b0;
  logic                        in_kind   = 1'b0;
  logic signed [SAMPLE_W-1:0]  in_sample = '0;
  logic                        out_pop   = 1'b0;
  logic                        cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0]        cfg_index = '0;
  logic [CFG_DATA_W-1:0]       cfg_data  = '0;

  // DUT outputs
  logic                        in_full;
  logic                        out_empty;
  logic                        out_report;
  logic signed [SAMPLE_W-1:0]  out_value;
  logic                        cfg_ready;

  distance_sample_qualifier dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_push    (in_push),
    .in_full    (in_full),
    .in_kind    (in_kind),
    .in_sample  (in_sample),
    .out_empty  (out_empty),
    .out_pop    (out_pop),
    .out_report (out_report),
    .out_value  (out_value),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #6 clk = ~clk;

  // Stimulus and scoreboard storage
  dist_beat_t    beat_queue[$];        // beats waiting for the driver
  dist_report_t  expected_reports[$];  // predicted results, oldest first
  int            n_queued    = 0;
  int            n_accepted  = 0;
  int            mismatches  = 0;
  bit            beat_taken  = 1'b0;   // beat on the bus went in at the last edge
  bit            calm        = 1'b0;   // no idling on either side
  int            gap_left    = 0;
  int            stall_left  = 0;
  int            track       = 0;      // scaled distance the walk generator follows

  // Model state: register copy plus the qualifier's own state
  cfg_t                cfg_shadow;
  logic [LIMIT_W-1:0]  invalid_run;
  int                  last_good;
  bit                  have_last_good;
  longint              window_sum;
  logic [WIN_W-1:0]    tick_count;

  function automatic void reset_model();
    cfg_shadow.scale          = 12'd256;
    cfg_shadow.min_normal     = 16'sd0;
    cfg_shadow.invalid_limit  = 8'd3;
    cfg_shadow.max_jump       = 15'd160;
    cfg_shadow.window_length  = 11'd10;
    invalid_run    = '0;
    last_good      = 0;
    have_last_good = 1'b0;
    window_sum     = 0;
    tick_count     = '0;
  endfunction

  function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_SCALE:      cfg_shadow.scale          = data[SCALE_W-1:0];
      REG_MIN_NORMAL: cfg_shadow.min_normal     = data;
      REG_INV_LIMIT:  cfg_shadow.invalid_limit  = data[LIMIT_W-1:0];
      REG_GAP:        cfg_shadow.max_jump       = data[GAP_W-1:0];
      REG_WINDOW:     cfg_shadow.window_length  = data[WIN_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic int clamp16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return int'(v);
  endfunction

  function automatic void add_to_window(int v);
    window_sum = window_sum + v;
    if (window_sum > 64'sd67108863) window_sum = 64'sd67108863;
    if (window_sum < -64'sd67108864) window_sum = -64'sd67108864;
  endfunction

  // One accepted beat: scale, qualify, accumulate, and queue any result.
  function automatic void qualify_beat(logic kind, logic signed [SAMPLE_W-1:0] smp);
    int           win;
    int           v;
    int           d;
    longint       prod;
    dist_report_t r;
    win = int'(cfg_shadow.window_length);
    if (win == 0) win = 1;
    if (win > int'(WINDOW_MAX)) win = int'(WINDOW_MAX);
    tick_count = tick_count + 1'b1;
    if (kind == KIND_SAMPLE) begin
      prod = longint'(smp) * longint'(cfg_shadow.scale);
      v = clamp16(prod >>> 8);   // floor shift, then saturate
      if (v < int'($signed(cfg_shadow.min_normal))) begin
        if (invalid_run != RUN_MAX) invalid_run = invalid_run + 1'b1;
        if (invalid_run > cfg_shadow.invalid_limit) begin
          // error wins over a window end on the same beat
          tick_count = '0;
          window_sum = 0;
          r.report = REPORT_ERROR;
          r.value  = v[SAMPLE_W-1:0];
          expected_reports.push_back(r);
          return;
        end
      end else begin
        d = v - last_good;
        if (d < 0) d = -d;
        invalid_run = '0;
        if (!have_last_good || d < int'(cfg_shadow.max_jump)) begin
          add_to_window(v);
          last_good = (v >= 0) ? (v & ~15) : -((-v) & ~15);
          have_last_good = 1'b1;
        end else begin
          add_to_window(last_good);
        end
      end
    end
    if (int'(tick_count) >= win) begin
      r.report = REPORT_AVG;
      v = clamp16(window_sum / longint'(win));
      r.value  = v[SAMPLE_W-1:0];
      tick_count = '0;
      window_sum = 0;
      expected_reports.push_back(r);
    end
  endfunction

  function automatic void check_result(logic report, logic signed [SAMPLE_W-1:0] value);
    dist_report_t e;
    if (expected_reports.size() == 0) begin
      mismatches++;
      if (mismatches <= SHOW_LIMIT)
        $display("%0t: unexpected result report=%0d value=%0d", $realtime, report, value);
      return;
    end
    e = expected_reports.pop_front();
    if (e.report !== report || e.value !== value) begin
      mismatches++;
      if (mismatches <= SHOW_LIMIT)
        $display("%0t: expected report=%0d value=%0d, got report=%0d value=%0d",
                 $realtime, e.report, e.value, report, value);
    end
  endfunction

  // Everything seen at the rising edge: register writes, accepted beats, results.
  always @(posedge clk) begin
    beat_taken = 1'b0;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) apply_reg(cfg_index, cfg_data);
      if (out_pop && !out_empty) check_result(out_report, out_value);
      if (in_push && !in_full) begin
        beat_taken = 1'b1;
        n_accepted++;
        qualify_beat(in_kind, in_sample);
      end
    end
  end

  // Input driver: hold a beat until it is taken, then either idle for a random
  // burst or put up the next queued beat.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_push <= 1'b0;
    end else if (in_push && !beat_taken) begin
      // beat still waiting on in_full
    end else if (gap_left != 0) begin
      in_push  <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (beat_queue.size() == 0) begin
      in_push <= 1'b0;
    end else if (!calm && $urandom_range(0, 3) == 0) begin
      in_push  <= 1'b0;
      gap_left <= $urandom_range(0, 6);
    end else begin
      in_push   <= 1'b1;
      in_kind   <= beat_queue[0].kind;
      in_sample <= beat_queue[0].sample;
      void'(beat_queue.pop_front());
    end
  end

  // Result side: pop most of the time, stall in random bursts.
  always @(negedge clk) begin
    if (calm) begin
      out_pop <= 1'b1;
    end else if (stall_left != 0) begin
      out_pop    <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 4) == 0) begin
      out_pop    <= 1'b0;
      stall_left <= $urandom_range(0, 6);
    end else begin
      out_pop <= 1'b1;
    end
  end

  task automatic push_beat(logic kind, logic signed [SAMPLE_W-1:0] s);
    dist_beat_t b;
    b.kind   = kind;
    b.sample = s;
    beat_queue.push_back(b);
    n_queued++;
  endtask

  // Register write; only called while the block is idle.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Wait until every beat is in and every predicted result is out, then let
  // any result-free beat still in the pipeline finish.
  task automatic wait_drained();
    while (n_accepted != n_queued || expected_reports.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Raw sample whose scaled value lands near the target.
  function automatic logic signed [SAMPLE_W-1:0] raw_for(int target);
    int r;
    if (cfg_shadow.scale == '0) begin
      r = $urandom;
      return r[SAMPLE_W-1:0];
    end
    r = (target * 256) / int'(cfg_shadow.scale);
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[SAMPLE_W-1:0];
  endfunction

  // Scaled value below min_normal, mostly just under it.
  function automatic int low_target();
    int mn;
    int span;
    int k;
    mn = int'($signed(cfg_shadow.min_normal));
    if (mn == -32768 || $urandom_range(0, 4) == 0) return -32768;
    span = mn + 32767;
    if (span > 3000) span = 3000;
    k = $urandom_range(0, span);
    return mn - 1 - k;
  endfunction

  // Random beats shaped by the current registers: mostly a slow walk that
  // passes the gap check, with jumps, invalid runs around the limit, empty
  // ticks and full-range noise mixed in.
  task automatic add_walk(int count);
    int pick;
    int len;
    int k;
    int mn;
    int gap;
    int lim;
    while (count > 0) begin
      mn  = int'($signed(cfg_shadow.min_normal));
      gap = int'(cfg_shadow.max_jump);
      lim = int'(cfg_shadow.invalid_limit);
      if (lim > 8) lim = 8;
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        push_beat(KIND_TICK, SAMPLE_W'($urandom));
        count--;
      end else if (pick < 23) begin
        push_beat(KIND_SAMPLE, SAMPLE_W'($urandom));
        count--;
      end else if (pick < 33) begin
        len = $urandom_range(1, lim + 2);
        repeat (len) push_beat(KIND_SAMPLE, raw_for(low_target()));
        count -= len;
      end else begin
        if (pick < 39) begin
          k = $urandom_range(0, 4 * gap + 64);
          if ($urandom_range(0, 1) == 1) track = track + gap + k;
          else track = track - gap - k;
        end else begin
          k = $urandom_range(0, gap + 2);
          track = track + k - (gap + 2) / 2;
        end
        if (track < mn) track = mn;
        if (track > 32767) track = 32767;
        push_beat(KIND_SAMPLE, raw_for(track));
        count--;
      end
    end
  endtask

  initial begin
    reset_model();
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // Directed beats at reset defaults: scale 1.0, min 0, limit 3, gap 160, window 10.
    push_beat(KIND_SAMPLE, 16'sd0);       // no previous value yet: taken
    push_beat(KIND_SAMPLE, 16'sd100);     // small jump: taken, last_good 96
    push_beat(KIND_SAMPLE, 16'sd32767);   // huge jump: previous value used
    push_beat(KIND_SAMPLE, -16'sd32768);  // invalid run 1
    push_beat(KIND_SAMPLE, -16'sd1);      // run 2
    push_beat(KIND_SAMPLE, -16'sd16);     // run 3, still tolerated
    push_beat(KIND_SAMPLE, -16'sd32768);  // run 4: error, window cleared
    push_beat(KIND_SAMPLE, -16'sd5);      // run 5: another error
    push_beat(KIND_SAMPLE, 16'sd80);      // valid again, run cleared
    push_beat(KIND_SAMPLE, 16'sd240);     // jump equal to gap: rejected
    push_beat(KIND_SAMPLE, 16'sd239);     // jump one under gap: taken
    repeat (7) push_beat(KIND_TICK, 16'sd0);        // tick 10: average
    // error landing on the window end: only the error comes out
    repeat (3) push_beat(KIND_SAMPLE, -16'sd1);
    repeat (6) push_beat(KIND_TICK, -16'sd1);
    push_beat(KIND_SAMPLE, -16'sd1);
    wait_drained();

    // Long window, part filled, then shortened: average due on the next beat.
    // Upper data bits are beyond the register width and must be dropped.
    write_reg(REG_WINDOW, 16'hF832);
    add_walk(30);
    wait_drained();
    write_reg(REG_WINDOW, 16'd10);
    add_walk(30);
    wait_drained();

    // Extremes: max scale, lowest min, zero limit and gap, window of one.
    write_reg(REG_SCALE, 16'h0FFF);
    write_reg(REG_MIN_NORMAL, 16'h8000);
    write_reg(REG_INV_LIMIT, 16'd0);
    write_reg(REG_GAP, 16'd0);
    write_reg(REG_WINDOW, 16'd1);
    add_walk(30);
    wait_drained();

    // Other extremes: zero scale (every sample scales to 0), top min, limit 254,
    // top gap, window register zero (acts as one).
    write_reg(REG_SCALE, 16'hF000);
    write_reg(REG_MIN_NORMAL, 16'h7FFF);
    write_reg(REG_INV_LIMIT, 16'd254);
    write_reg(REG_GAP, 16'h7FFF);
    write_reg(REG_WINDOW, 16'hF800);
    add_walk(30);
    wait_drained();
    // Window above the maximum, and a run long enough to pass limit 254 and
    // saturate the run counter; every sample here is below min.
    write_reg(REG_MIN_NORMAL, 16'd100);
    write_reg(REG_WINDOW, 16'h07FF);
    repeat (230) push_beat(KIND_SAMPLE, SAMPLE_W'($urandom));
    wait_drained();
    // Limit 255: a saturated run never exceeds it, so no more errors.
    write_reg(REG_INV_LIMIT, 16'hFFFF);
    repeat (20) push_beat(KIND_SAMPLE, SAMPLE_W'($urandom));
    wait_drained();

    // Undecoded indexes must leave the registers alone.
    write_reg(REG_SPARE_A, CFG_DATA_W'($urandom));
    write_reg(REG_SPARE_B, CFG_DATA_W'($urandom));
    write_reg(REG_SPARE_C, CFG_DATA_W'($urandom));
    // Window shrinks from 1024 with ticks pending.
    write_reg(REG_WINDOW, 16'd10);
    write_reg(REG_SCALE, 16'h0100);
    add_walk(20);
    wait_drained();

    // Random register settings, mostly in the useful range.
    repeat (4) begin
      write_reg(REG_SCALE, ($urandom_range(0, 3) == 0) ? CFG_DATA_W'($urandom)
                                                       : CFG_DATA_W'($urandom_range(128, 640)));
      write_reg(REG_MIN_NORMAL, CFG_DATA_W'($urandom_range(0, 600) - 300));
      write_reg(REG_INV_LIMIT, CFG_DATA_W'($urandom_range(0, 6)));
      write_reg(REG_GAP, CFG_DATA_W'($urandom_range(16, 900)));
      write_reg(REG_WINDOW, CFG_DATA_W'($urandom_range(1, 24)));
      add_walk(20);
      wait_drained();
    end

    // Back to defaults and run flat out with no idling.
    write_reg(REG_SCALE, 16'd256);
    write_reg(REG_MIN_NORMAL, 16'd0);
    write_reg(REG_INV_LIMIT, 16'd3);
    write_reg(REG_GAP, 16'd160);
    write_reg(REG_WINDOW, 16'd10);
    calm = 1'b1;
    add_walk(60);
    wait_drained();

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run.
  initial begin
    #6_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

[distance_sample_qualifier.f]
hw/rtl/dsq_pkg.sv
hw/rtl/dsq_fifo.sv
hw/rtl/dsq_front.sv
hw/rtl/dsq_back.sv
hw/rtl/distance_sample_qualifier.sv
test/distance_sample_qualifier_test.sv
